>>> sv/sws_pkg.sv
package sws_pkg;

	localparam int FUNC_W  = 2;
	localparam int TIMER_W = 2;
	localparam int CFG_W   = 3;

	localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 3'd4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SEND    = 2'd0,
		FUNC_ACK     = 2'd1,
		FUNC_TIMEOUT = 2'd2
	} func_t;

	typedef enum logic [TIMER_W-1:0] {
		TMR_NONE    = 2'd0,
		TMR_START   = 2'd1,
		TMR_STOP    = 2'd2,
		TMR_RESTART = 2'd3
	} timer_t;

	// control part of one result item
	typedef struct packed {
		logic   strobe;
		logic   send_accepted;
		logic   tx_valid;
		logic   retx;
		timer_t timer_action;
		logic   window_full;
	} res_ctrl_t;

endpackage

>>> sv/sws_ram.sv
module sws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/sws_ctrl.sv
module sws_ctrl #(
	parameter int WINDOW_DEPTH = 4,
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      item_valid,
	input  logic [sws_pkg::FUNC_W-1:0]                func,
	input  logic [PAYLOAD_BITS-1:0]                   payload_word,
	input  logic [SEQ_BITS-1:0]                       ack_number,
	input  logic                                      ack_checksum_ok,
	input  logic [sws_pkg::CFG_W-1:0]                 window_size,
	output sws_pkg::res_ctrl_t                        res,
	output logic [SEQ_BITS-1:0]                       tx_sequence_s1,
	output logic [PAYLOAD_BITS-1:0]                   tx_payload_s1,
	output logic                                      ram_we,
	output logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] ram_waddr,
	output logic [PAYLOAD_BITS-1:0]                   ram_wdata,
	output logic                                      ram_re,
	output logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] ram_raddr
);

	localparam int AW      = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SEQ_MAX = (1 << SEQ_BITS) - 1;
	localparam int CAP     = WINDOW_DEPTH < SEQ_MAX ? WINDOW_DEPTH : SEQ_MAX;
	localparam int CNTW    = $clog2(CAP + 1);
	localparam int SUMW    = (AW > CNTW ? AW : CNTW) + 1;
	localparam int WW      = CNTW > sws_pkg::CFG_W ? CNTW : sws_pkg::CFG_W;

	logic [AW-1:0]       head_q, head_n;
	logic [SEQ_BITS-1:0] base_q, base_n;
	logic [SEQ_BITS-1:0] next_q, next_n;
	logic [CNTW-1:0]     count_q, count_n;
	logic [SEQ_BITS-1:0] last_q, last_n;
	logic                seen_q, seen_n;
	logic [1:0]          dup_q, dup_n;
	logic                waiting_q, waiting_n;

	logic [CNTW-1:0]     win;
	logic [WW-1:0]       ws_ext;
	logic [SEQ_BITS-1:0] ack_offset;
	logic                in_range;
	logic [CNTW-1:0]     slide_n;
	logic [1:0]          dup_inc;

	sws_pkg::res_ctrl_t  res_d;
	logic [SEQ_BITS-1:0] seq_d;
	logic [PAYLOAD_BITS-1:0] pay_d;
	logic                send_ok;

	// slot index modulo the depth; the sum never reaches twice the depth
	function automatic logic [AW-1:0] slot_add(logic [AW-1:0] h, logic [CNTW-1:0] k);
		logic [SUMW-1:0] s;
		s = SUMW'(h) + SUMW'(k);
		if (s >= SUMW'(WINDOW_DEPTH)) begin
			s = s - SUMW'(WINDOW_DEPTH);
		end
		return AW'(s);
	endfunction

	always_comb begin
		ws_ext = WW'(window_size);
		if (window_size == '0) begin
			win = CNTW'(1);
		end else if (ws_ext > WW'(CAP)) begin
			win = CNTW'(CAP);
		end else begin
			win = CNTW'(ws_ext);
		end
	end

	assign ack_offset = ack_number - base_q;
	assign in_range   = ack_offset < SEQ_BITS'(count_q);
	assign slide_n    = CNTW'(ack_offset) + CNTW'(1);

	always_comb begin
		head_n    = head_q;
		base_n    = base_q;
		next_n    = next_q;
		count_n   = count_q;
		last_n    = last_q;
		seen_n    = seen_q;
		dup_n     = dup_q;
		waiting_n = waiting_q;
		dup_inc   = '0;
		send_ok   = 1'b0;
		res_d     = '0;
		seq_d     = '0;
		pay_d     = '0;

		case (sws_pkg::func_t'(func))
			sws_pkg::FUNC_SEND: begin
				if (waiting_q || count_q >= win) begin
					waiting_n = 1'b1;
				end else begin
					send_ok             = 1'b1;
					res_d.send_accepted = 1'b1;
					res_d.tx_valid      = 1'b1;
					seq_d               = next_q;
					pay_d               = payload_word;
					res_d.timer_action  = (count_q == '0) ? sws_pkg::TMR_START
					                                      : sws_pkg::TMR_NONE;
					count_n             = count_q + CNTW'(1);
					if (count_n >= win) begin
						waiting_n = 1'b1;
					end
					next_n = next_q + SEQ_BITS'(1);
				end
			end
			sws_pkg::FUNC_ACK: begin
				if (ack_checksum_ok && count_q != '0) begin
					if (in_range) begin
						head_n  = slot_add(head_q, slide_n);
						count_n = count_q - slide_n;
						base_n  = ack_number + SEQ_BITS'(1);
					end
					res_d.timer_action = (count_n != '0) ? sws_pkg::TMR_RESTART
					                                     : sws_pkg::TMR_STOP;
					if (seen_q && ack_number == last_q) begin
						dup_inc = dup_q + 2'd1;
					end else begin
						last_n  = ack_number;
						seen_n  = 1'b1;
						dup_inc = '0;
					end
					// third repeat: fast retransmit of the oldest item
					if (dup_inc == 2'd3) begin
						dup_n = '0;
						if (count_n != '0) begin
							res_d.tx_valid     = 1'b1;
							res_d.retx         = 1'b1;
							seq_d              = base_n;
							res_d.timer_action = sws_pkg::TMR_RESTART;
						end
					end else begin
						dup_n = dup_inc;
					end
					if (count_n < win) begin
						waiting_n = 1'b0;
					end
				end
			end
			sws_pkg::FUNC_TIMEOUT: begin
				if (count_q != '0) begin
					res_d.tx_valid     = 1'b1;
					res_d.retx         = 1'b1;
					seq_d              = base_q;
					res_d.timer_action = sws_pkg::TMR_RESTART;
				end
			end
			default: begin
			end
		endcase

		res_d.strobe      = 1'b1;
		res_d.window_full = waiting_n;
	end

	assign ram_we    = item_valid && send_ok;
	assign ram_waddr = slot_add(head_q, count_q);
	assign ram_wdata = payload_word;
	assign ram_re    = item_valid && res_d.retx;
	assign ram_raddr = head_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			base_q    <= '0;
			next_q    <= '0;
			count_q   <= '0;
			last_q    <= '0;
			seen_q    <= 1'b0;
			dup_q     <= '0;
			waiting_q <= 1'b0;
			res       <= '0;
		end else if (item_valid) begin
			head_q    <= head_n;
			base_q    <= base_n;
			next_q    <= next_n;
			count_q   <= count_n;
			last_q    <= last_n;
			seen_q    <= seen_n;
			dup_q     <= dup_n;
			waiting_q <= waiting_n;
			res       <= res_d;
		end else begin
			// drop the strobe, hold the rest
			res.strobe <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid) begin
			tx_sequence_s1 <= seq_d;
			tx_payload_s1  <= pay_d;
		end
	end

endmodule

>>> sv/sliding_window_sender_core.sv
// Sliding window sender. Every item taken on start gives exactly one result, shown with done
// high in the very next cycle, so one item per cycle is sustained and busy stays low. Pointers
// and counters sit in registers; payload words sit in a small RAM with a registered
// read, and a retransmission reads the oldest slot in the cycle the item is taken, so its word
// arrives together with the result. Results cannot be held off: take done when it is high.
// The window size register may be written at any time the block is idle; cfg_ready is
// always high.
module sliding_window_sender_core #(
	parameter int WINDOW_DEPTH = 4,
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sws_pkg::FUNC_W-1:0]    func,
	input  logic [PAYLOAD_BITS-1:0]       payload_word,
	input  logic [SEQ_BITS-1:0]           ack_number,
	input  logic                          ack_checksum_ok,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sws_pkg::CFG_W-1:0]     cfg_data,
	output logic                          done,
	output logic                          send_accepted,
	output logic                          tx_valid,
	output logic [SEQ_BITS-1:0]           tx_sequence,
	output logic [PAYLOAD_BITS-1:0]       tx_payload,
	output logic [sws_pkg::TIMER_W-1:0]   timer_action,
	output logic                          window_full
);

	localparam int AW = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;

	logic [sws_pkg::CFG_W-1:0] window_size_q;
	logic                      item_valid;
	sws_pkg::res_ctrl_t        res;
	logic [SEQ_BITS-1:0]       seq_s1;
	logic [PAYLOAD_BITS-1:0]   pay_s1;
	logic                      ram_we, ram_re;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	logic [PAYLOAD_BITS-1:0]   ram_wdata, ram_rdata;

	assign busy       = 1'b0;
	assign cfg_ready  = 1'b1;
	assign item_valid = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= sws_pkg::WINDOW_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_size_q <= cfg_data;
		end
	end

	sws_ctrl #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.func           (func),
		.payload_word   (payload_word),
		.ack_number     (ack_number),
		.ack_checksum_ok(ack_checksum_ok),
		.window_size    (window_size_q),
		.res            (res),
		.tx_sequence_s1 (seq_s1),
		.tx_payload_s1  (pay_s1),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr)
	);

	sws_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign done          = res.strobe;
	assign send_accepted = res.send_accepted;
	assign tx_valid      = res.tx_valid;
	assign tx_sequence   = seq_s1;
	// retransmitted words come from the RAM read issued with the item
	assign tx_payload    = res.retx ? ram_rdata : pay_s1;
	assign timer_action  = res.timer_action;
	assign window_full   = res.window_full;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |=> done)
		else $error("item taken without a result");

	a_send_timer: assert property (@(posedge clk) disable iff (!arst_n)
		done && send_accepted |->
			tx_valid && (timer_action == sws_pkg::TMR_START ||
			             timer_action == sws_pkg::TMR_NONE))
		else $error("accepted send without transmit or with wrong timer");

	a_full_refuses: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && func == sws_pkg::FUNC_SEND && window_full |=>
			!send_accepted && window_full)
		else $error("send taken while window full");

	a_retx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done && tx_valid && !send_accepted |-> timer_action == sws_pkg::TMR_RESTART)
		else $error("retransmission without timer restart");

endmodule
